/* hw/rtl/sg3_pkg.sv */
// ----------------------------------------------------------------------------
// sg3_pkg
// Shared widths, register indexes and types of the 3x3 Sobel gradient core.
// ----------------------------------------------------------------------------
package sg3_pkg;

  localparam int PIX_W        = 8;
  localparam int GRAD_W       = 11;
  localparam int COORD_W      = 10;
  localparam int CFG_W        = 11;
  localparam int CFG_ADDR_W   = 1;
  localparam int OUT_DATA_W   = 48;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  typedef struct packed {
    logic interior;
    logic last;
  } pos_flags_t;

endpackage

/* hw/rtl/sg3_ram.sv */
// ----------------------------------------------------------------------------
// sg3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sg3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sg3_pos.sv */
// ----------------------------------------------------------------------------
// sg3_pos
// Frame geometry registers and raster position counters.
// ----------------------------------------------------------------------------
module sg3_pos #(
  parameter int MAX_WIDTH  = sg3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sg3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sg3_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [sg3_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           step_i,
  output logic [$clog2(MAX_WIDTH)-1:0]   col_o,
  output logic [sg3_pkg::COORD_W-1:0]    center_row_o,
  output logic [sg3_pkg::COORD_W-1:0]    center_col_o,
  output sg3_pkg::pos_flags_t            flags_o
);
  import sg3_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int XWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int XHW = (HW > CFG_W) ? HW : CFG_W;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;

  logic [XWW-1:0] width_x;
  logic [XHW-1:0] height_x;
  logic [WW-1:0]  w_eff, c_inc;
  logic [HW-1:0]  h_eff, row_pre, r_inc;
  logic [CW-1:0]  c_cur;
  logic [RW-1:0]  r_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturate geometry to 3..MAX
  always_comb begin
    width_x  = XWW'(width_q);
    height_x = XHW'(height_q);
    if (width_x < XWW'(3)) begin
      w_eff = WW'(3);
    end else if (width_x > XWW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_x);
    end
    if (height_x < XHW'(3)) begin
      h_eff = HW'(3);
    end else if (height_x > XHW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_x);
    end
  end

  always_comb begin
    // wrap first in case the geometry shrank since the last transaction
    if (WW'(col_q) >= w_eff) begin
      c_cur   = '0;
      row_pre = HW'(row_q) + HW'(1);
    end else begin
      c_cur   = col_q;
      row_pre = HW'(row_q);
    end
    r_cur = (row_pre >= h_eff) ? '0 : RW'(row_pre);

    c_inc = WW'(c_cur) + WW'(1);
    r_inc = HW'(r_cur) + HW'(1);
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= h_eff) ? '0 : RW'(r_inc);
    end else begin
      col_d = CW'(c_inc);
      row_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o            = c_cur;
  assign center_row_o     = COORD_W'(r_cur - RW'(1));
  assign center_col_o     = COORD_W'(c_cur - CW'(1));
  assign flags_o.interior = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
  assign flags_o.last     = (HW'(r_cur) == h_eff - HW'(1)) && (WW'(c_cur) == w_eff - WW'(1));

endmodule

/* hw/rtl/sg3_grad.sv */
// ----------------------------------------------------------------------------
// sg3_grad
// 3x3 window registers and Sobel x/y gradient arithmetic.
// ----------------------------------------------------------------------------
module sg3_grad (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               shift_i,
  input  logic        [sg3_pkg::PIX_W-1:0]   top_i,
  input  logic        [sg3_pkg::PIX_W-1:0]   mid_i,
  input  logic        [sg3_pkg::PIX_W-1:0]   bot_i,
  output logic signed [sg3_pkg::GRAD_W-1:0]  grad_horiz_o,
  output logic signed [sg3_pkg::GRAD_W-1:0]  grad_vert_o
);
  import sg3_pkg::*;

  localparam int EXT = GRAD_W - PIX_W;

  // 0..2: column c-2 (top, mid, bottom), 3..5: column c-1
  logic [PIX_W-1:0] win_q [6];

  logic signed [GRAD_W-1:0] tl, ml, bl, tm, bm, tr, mr, br;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_i;
      win_q[4] <= mid_i;
      win_q[5] <= bot_i;
    end
  end

  assign tl = $signed({{EXT{1'b0}}, win_q[0]});
  assign ml = $signed({{EXT{1'b0}}, win_q[1]});
  assign bl = $signed({{EXT{1'b0}}, win_q[2]});
  assign tm = $signed({{EXT{1'b0}}, win_q[3]});
  assign bm = $signed({{EXT{1'b0}}, win_q[5]});
  assign tr = $signed({{EXT{1'b0}}, top_i});
  assign mr = $signed({{EXT{1'b0}}, mid_i});
  assign br = $signed({{EXT{1'b0}}, bot_i});

  assign grad_horiz_o = (tr + (mr <<< 1) + br) - (tl + (ml <<< 1) + bl);
  assign grad_vert_o  = (bl + (bm <<< 1) + br) - (tl + (tm <<< 1) + tr);

endmodule

/* hw/rtl/sobel_gradient_3x3_core.sv */
// An input transaction passes stage 1 and the output registers to the master side.
// Throughput: one pixel per cycle unless m_axis stalls; the line store RAM read
// is issued on accept and its registered data meets the window in the following stage.
// Reset clears position counters, window and pipeline valids, and loads the
// geometry registers with 640 x 480. Line store contents are not cleared.
// ----------------------------------------------------------------------------
// sobel_gradient_3x3_core
// Streaming 3x3 Sobel gradient over 8-bit gray pixels in raster order.
// ----------------------------------------------------------------------------
module sobel_gradient_3x3_core #(
  parameter int MAX_WIDTH  = sg3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sg3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sg3_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [sg3_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sg3_pkg::PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [10:0] grad_horiz, [21:11] grad_vert, [31:22] center_row,
  // [41:32] center_col, [47:42] zero
  output logic [sg3_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast    // frame_end
);
  import sg3_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PAD_W = OUT_DATA_W - 2 * GRAD_W - 2 * COORD_W;

  logic                 accept, advance, s1_fire;
  logic [CW-1:0]        col;
  logic [COORD_W-1:0]   center_row, center_col;
  pos_flags_t           flags;

  logic                 s1_valid_q;
  logic [PIX_W-1:0]     s1_pix_q;
  logic [CW-1:0]        s1_col_q;
  logic [COORD_W-1:0]   s1_row_c_q, s1_col_c_q;
  pos_flags_t           s1_flags_q;

  logic [2*PIX_W-1:0]   lines_rd;
  logic [PIX_W-1:0]     top, mid;
  logic signed [GRAD_W-1:0] grad_horiz, grad_vert;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s1_fire       = s1_valid_q && advance;

  sg3_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .step_i       (accept),
    .col_o        (col),
    .center_row_o (center_row),
    .center_col_o (center_col),
    .flags_o      (flags)
  );

  // word = {row above previous (top), previous row (mid)}
  sg3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i ({mid, s1_pix_q}),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (lines_rd)
  );

  assign top = lines_rd[2*PIX_W-1:PIX_W];
  assign mid = lines_rd[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= s_axis_tdata;
      s1_col_q   <= col;
      s1_row_c_q <= center_row;
      s1_col_c_q <= center_col;
      s1_flags_q <= flags;
    end
  end

  sg3_grad u_grad (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (s1_fire),
    .top_i        (top),
    .mid_i        (mid),
    .bot_i        (s1_pix_q),
    .grad_horiz_o (grad_horiz),
    .grad_vert_o  (grad_vert)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && s1_flags_q.interior;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_flags_q.interior) begin
      out_data_q <= {{PAD_W{1'b0}}, s1_col_c_q, s1_row_c_q, grad_vert, grad_horiz};
      out_last_q <= s1_flags_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_pix_q) && $stable(s1_col_q))
    else $error("stage 1 transaction changed while stalled");

  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel did not reach stage 1");

  a_result_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_flags_q.interior |=> m_axis_tvalid)
    else $error("interior pixel produced no result");

  a_border_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !(s1_valid_q && s1_flags_q.interior) |=> !m_axis_tvalid)
    else $error("result produced without an interior pixel");

endmodule

/* verif/sobel_grad_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_grad_checker
// Follows register writes and pixel transactions of the 3x3 Sobel gradient
// core. It keeps its own line stores, window and raster position, predicts
// every gradient transaction and compares it field by field on the master
// side. It reports the failure count, the number of gradients still due and
// the pixels left to the end of the current frame.
// ----------------------------------------------------------------------------
module sobel_grad_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sg3_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [sg3_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           pix_valid_i,
  input  logic                           pix_ready_i,
  input  logic [sg3_pkg::PIX_W-1:0]      pix_data_i,
  input  logic                           grad_valid_i,
  input  logic                           grad_ready_i,
  input  logic [sg3_pkg::OUT_DATA_W-1:0] grad_data_i,
  input  logic                           grad_last_i,
  output int                             err_count_o,
  output int                             grads_due_o,
  output int                             frame_left_o
);
  import sg3_pkg::*;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic                     frame_end;
  } grad_t;

  grad_t            grads_due[$];
  logic [PIX_W-1:0] line_prev [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] line_older[MAX_WIDTH_DEF];
  logic [PIX_W-1:0] win[6];
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int               fails = 0;
  int               due_n = 0;
  int               left_n = 0;

  assign err_count_o  = fails;
  assign grads_due_o  = due_n;
  assign frame_left_o = left_n;

  function automatic int unsigned dim_of(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic take_pixel(input logic [PIX_W-1:0] pix);
    int unsigned      w, h, r, c;
    logic [PIX_W-1:0] top8, mid8;
    int               top, mid, bot, tl, ml, bl, tm, bm, gx, gy;
    grad_t            g;
    w = dim_of(width_reg, MAX_WIDTH_DEF);
    h = dim_of(height_reg, MAX_HEIGHT_DEF);
    // geometry may have shrunk under the current position
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    top8 = line_older[c];
    mid8 = line_prev[c];
    top = int'(top8);
    mid = int'(mid8);
    bot = int'(pix);
    if (r >= 2 && c >= 2) begin
      tl = int'(win[0]);
      ml = int'(win[1]);
      bl = int'(win[2]);
      tm = int'(win[3]);
      bm = int'(win[5]);
      gx = (top + 2 * mid + bot) - (tl + 2 * ml + bl);
      gy = (bl + 2 * bm + bot) - (tl + 2 * tm + top);
      g.gx = GRAD_W'(gx);
      g.gy = GRAD_W'(gy);
      g.row = COORD_W'(r - 1);
      g.col = COORD_W'(c - 1);
      g.frame_end = (r == h - 1) && (c == w - 1);
      grads_due.push_back(g);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top8;
    win[4] = mid8;
    win[5] = pix;
    line_older[c] = mid8;
    line_prev[c]  = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_grad();
    grad_t                    want;
    logic signed [GRAD_W-1:0] gx, gy;
    logic [COORD_W-1:0]       row, col;
    gx  = grad_data_i[GRAD_W-1:0];
    gy  = grad_data_i[2*GRAD_W-1:GRAD_W];
    row = grad_data_i[2*GRAD_W +: COORD_W];
    col = grad_data_i[2*GRAD_W+COORD_W +: COORD_W];
    if (grads_due.size() == 0) begin
      $error("unexpected gradient: grad_horiz %0d grad_vert %0d centre (%0d,%0d)",
             gx, gy, row, col);
      fails++;
      return;
    end
    want = grads_due.pop_front();
    if (gx !== want.gx) begin
      $error("grad_horiz: expected %0d, got %0d", want.gx, gx);
      fails++;
    end
    if (gy !== want.gy) begin
      $error("grad_vert: expected %0d, got %0d", want.gy, gy);
      fails++;
    end
    if (row !== want.row) begin
      $error("center_row: expected %0d, got %0d", want.row, row);
      fails++;
    end
    if (col !== want.col) begin
      $error("center_col: expected %0d, got %0d", want.col, col);
      fails++;
    end
    if (grad_last_i !== want.frame_end) begin
      $error("frame_end: expected %0d, got %0d", want.frame_end, grad_last_i);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned w, h, r, c;
    if (!rst_ni) begin
      grads_due.delete();
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        line_prev[i]  = '0;
        line_older[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
    end else begin
      if (grad_valid_i && grad_ready_i) check_grad();
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_IDX_WIDTH:  width_reg  = cfg_data_i;
          CFG_IDX_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) take_pixel(pix_data_i);
    end
    w = dim_of(width_reg, MAX_WIDTH_DEF);
    h = dim_of(height_reg, MAX_HEIGHT_DEF);
    r = row_pos;
    c = col_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    left_n = (h - r) * w - c;
    due_n  = grads_due.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds gray pixel frames into the 3x3 Sobel gradient core: a short run at
// the reset geometry, frames with gradient extremes, the widest and tallest
// geometry, then frames of random small geometry with mid-frame shrinks and
// height changes. Both stream sides idle at random; the checker predicts and
// compares every gradient transaction.
// ----------------------------------------------------------------------------
module tb_top;
  import sg3_pkg::*;

  localparam int RANDOM_PIXELS = 360;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 6;

  typedef enum int {PIX_NOISE, PIX_EXTREME, PIX_FLAT} pix_style_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_IDX_WIDTH;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  int                    fail_count;
  int                    grads_due;
  int                    frame_left;
  bit                    calm = 1'b0;
  int unsigned           cur_width = 640;
  int                    cycle_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sobel_gradient_3x3_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  sobel_grad_checker u_grad_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .pix_valid_i  (s_tvalid),
    .pix_ready_i  (s_tready),
    .pix_data_i   (s_tdata),
    .grad_valid_i (m_tvalid),
    .grad_ready_i (m_tready),
    .grad_data_i  (m_tdata),
    .grad_last_i  (m_tlast),
    .err_count_o  (fail_count),
    .grads_due_o  (grads_due),
    .frame_left_o (frame_left)
  );

  function automatic int unsigned wait_draw();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 8);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned gap;
    bit          taken;
    gap = wait_draw();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_block(input int n, input pix_style_e style);
    logic [PIX_W-1:0] base;
    base = PIX_W'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      case (style)
        PIX_EXTREME: send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
        PIX_FLAT:    send_pixel(base + PIX_W'($urandom_range(0, 3)));
        default:     send_pixel(PIX_W'($urandom));
      endcase
    end
  endtask

  // all gradients in, then let the pipeline empty of border pixels
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (grads_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
    settle();
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_IDX_WIDTH) begin
      cur_width = (val < 3) ? 3 : (val > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : val;
    end
  endtask

  initial begin : sink
    int unsigned stall;
    bit          hit;
    @(posedge clk);
    forever begin
      stall = wait_draw();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        hit = m_tvalid;
        @(posedge clk);
      end while (!hit);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned n_rand, left;
    pix_style_e  style;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry 640 x 480: part of the first row
    send_block(60, PIX_NOISE);

    // shrink mid-frame: the column wraps to the next row, then finish the frame
    set_reg(CFG_IDX_WIDTH, 3);
    set_reg(CFG_IDX_HEIGHT, 2);
    settle();
    send_block(frame_left, PIX_NOISE);

    // 4 x 3: horizontal gradient at both extremes
    set_reg(CFG_IDX_WIDTH, 4);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        send_pixel((c == 1 || c == 2) ? 8'hFF : 8'h00);
      end
    end

    // 4 x 4: vertical gradient at both extremes
    set_reg(CFG_IDX_HEIGHT, 4);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        send_pixel((r == 0 || r == 3) ? 8'hFF : 8'h00);
      end
    end

    // widest geometry, saturated, cut short by a width shrink
    set_reg(CFG_IDX_WIDTH, 2047);
    set_reg(CFG_IDX_HEIGHT, 0);
    send_block(40, PIX_NOISE);
    set_reg(CFG_IDX_WIDTH, 3);
    settle();
    send_block(frame_left, PIX_NOISE);

    // tallest geometry, saturated, cut short by a height shrink
    set_reg(CFG_IDX_HEIGHT, 2047);
    send_block(30, PIX_NOISE);
    set_reg(CFG_IDX_HEIGHT, 3);
    settle();
    send_block(frame_left, PIX_NOISE);

    n_rand = 0;
    while (n_rand < RANDOM_PIXELS) begin
      calm  = ($urandom_range(0, 3) == 0);
      style = pix_style_e'($urandom_range(0, 2));
      // frame start: any geometry is safe here
      set_reg(CFG_IDX_WIDTH,
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10));
      set_reg(CFG_IDX_HEIGHT,
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8));
      settle();
      left = frame_left;
      if ($urandom_range(0, 3) != 0) begin
        send_block(left, style);
        n_rand += left;
      end else begin
        left = $urandom_range(1, left - 1);
        send_block(left, style);
        n_rand += left;
        // mid-frame change: width may only shrink so no stale column is read
        if ($urandom_range(0, 1) != 0) begin
          set_reg(CFG_IDX_HEIGHT, $urandom_range(0, 8));
        end else begin
          set_reg(CFG_IDX_WIDTH, $urandom_range(0, cur_width));
        end
        settle();
        left = frame_left;
        send_block(left, style);
        n_rand += left;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
